### rtl/core/shpi_pkg.sv
package shpi_pkg;

   // Fixed field widths
   localparam int unsigned STAMP_BITS  = 7;
   localparam int unsigned HASH_PORT_W = 32;
   localparam int unsigned LB_PORT_W   = 4;

   // Stamp byte codes
   localparam logic [7:0]  EMPTY_MARK = 8'h80;
   localparam logic [63:0] EMPTY_WORD = 64'h8080_8080_8080_8080;

   // Above this log2 block count the fill limit is three quarters, else half
   localparam int unsigned SMALL_LOG = 9;

   // Request commands
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_PROBE  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clr_restart;   // take new log_blocks, restart the clearing sweep
      logic clr_write;     // write one empty block, advance sweep
      logic load;          // capture request beat, issue block read
      logic commit;        // resolve block, write back, load response
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;      // sweep address is the last block in use
      logic out_busy;      // response register full and not taken this cycle
   } ctrl_stat_type;

endpackage

### rtl/core/shpi_ram.sv
module shpi_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/shpi_ctrl.sv
module shpi_ctrl
   import shpi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          csr_valid,
   output logic          csr_ready,
   output ctrl_cmd_type  cmd,
   input  ctrl_stat_type stat
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            if (csr_valid) begin
               cmd.clr_restart = 1'b1;
            end else begin
               cmd.clr_write = 1'b1;
               if (stat.clr_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            req_ready = !csr_valid;
            if (csr_valid) begin
               cmd.clr_restart = 1'b1;
               state_in        = ST_CLEAR;
            end else if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // log_blocks writes wait until the beat in hand is resolved
            csr_ready = 1'b0;
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a loaded beat always moves the controller to the exec state, where it is resolved
   a_load_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_EXEC)
      else $error("load not followed by exec state");

   // sweep writes and item work never overlap
   a_clear_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_write && (cmd.load || cmd.commit)))
      else $error("clear write overlaps item work");
`endif

endmodule

### rtl/core/shpi_dp.sv
module shpi_dp
   import shpi_pkg::*;
#(
   parameter int unsigned LOG_BLOCKS_MAX = 10,
   parameter int unsigned HASH_BITS      = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ctrl_cmd_type                cmd,
   output ctrl_stat_type               stat,
   input  logic [LB_PORT_W-1:0]        csr_log_blocks,
   input  logic                        req_command,
   input  logic [HASH_PORT_W-1:0]      req_hash,
   input  logic [LOG_BLOCKS_MAX+2:0]   req_resume_slot,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_hit,
   output logic                        rsp_inserted,
   output logic                        rsp_table_full,
   output logic [LOG_BLOCKS_MAX+2:0]   rsp_gid,
   output logic [LOG_BLOCKS_MAX+2:0]   rsp_next_slot
);

   localparam int unsigned BLK_W  = LOG_BLOCKS_MAX;
   localparam int unsigned SLOT_W = LOG_BLOCKS_MAX + 3;
   localparam int unsigned LB_W   = $clog2(LOG_BLOCKS_MAX + 1);
   localparam int unsigned DEPTH  = 1 << LOG_BLOCKS_MAX;
   localparam int unsigned ROW_W  = 8 * SLOT_W;

   // Configuration and counters
   logic [LB_W-1:0]   lb_ff, lb_in;
   logic [BLK_W-1:0]  clr_ff, clr_in;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic [BLK_W-1:0]  bmask;
   logic [SLOT_W-1:0] slot_mask;
   logic [SLOT_W-1:0] limit;

   // Captured request
   logic                  cmd_ff;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic [BLK_W-1:0]      blk_ff, blk_in;
   logic [2:0]            from_ff, from_in;

   // Request decode
   logic [HASH_BITS-1:0] hv;
   logic [5:0]           sh_blk, sh_stamp;
   logic [SLOT_W-1:0]    req_slot;

   // Block memories
   logic [63:0]        st_rd, st_wr, st_new;
   logic               st_we;
   logic [BLK_W-1:0]   st_waddr;
   logic [ROW_W-1:0]   grp_rd, grp_new;
   logic               grp_we;

   // Block resolution
   logic [7:0]        sbyte [8];
   logic [SLOT_W-1:0] gslot [8];
   logic [7:0]        empty, eq, any;
   logic              hit;
   logic [3:0]        pos;
   logic [SLOT_W:0]   nxt_sum;
   logic              full, ins;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              match_ff, match_in;
   logic              ins_ff, full_ff;
   logic [SLOT_W-1:0] gid_ff, gid_in;
   logic [SLOT_W-1:0] next_ff, next_in;

   // Masks and fill limit for the blocks in use
   always_comb begin
      bmask     = ~({BLK_W{1'b1}} << lb_ff);
      slot_mask = {bmask, 3'b111};
      if (5'(lb_ff) <= 5'(SMALL_LOG)) begin
         limit = SLOT_W'(4) << lb_ff;
      end else begin
         limit = SLOT_W'(6) << lb_ff;
      end
   end

   // Request decode: stamp and block address
   always_comb begin
      hv       = req_hash[HASH_BITS-1:0];
      sh_blk   = 6'(HASH_BITS) - 6'(lb_ff);
      sh_stamp = 6'(HASH_BITS - STAMP_BITS) - 6'(lb_ff);
      stamp_in = STAMP_BITS'(hv >> sh_stamp);
      req_slot = req_resume_slot & slot_mask;
      if (req_command == CMD_LOOKUP) begin
         blk_in  = BLK_W'(hv >> sh_blk) & bmask;
         from_in = 3'd0;
      end else begin
         blk_in  = req_slot[SLOT_W-1:3];
         from_in = req_slot[2:0];
      end
   end

   // Configuration, sweep and fill count
   always_comb begin
      lb_in    = lb_ff;
      clr_in   = clr_ff;
      count_in = count_ff;
      if (cmd.clr_restart) begin
         if (5'(csr_log_blocks) > 5'(LOG_BLOCKS_MAX)) begin
            lb_in = LB_W'(LOG_BLOCKS_MAX);
         end else begin
            lb_in = LB_W'(csr_log_blocks);
         end
         clr_in   = '0;
         count_in = '0;
      end else begin
         if (cmd.clr_write) begin
            clr_in = clr_ff + BLK_W'(1);
         end
         if (cmd.commit && ins) begin
            count_in = count_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lb_ff    <= '0;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         lb_ff    <= lb_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_command;
         stamp_ff <= stamp_in;
         blk_ff   <= blk_in;
         from_ff  <= from_in;
      end
   end

   // Stamp words, one per block; slot s sits in byte 7-s
   shpi_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_stamp_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wr),
      .rd_en   (cmd.load),
      .rd_addr (blk_in),
      .rd_data (st_rd)
   );

   // Group id rows, one per block; slot s sits in field s
   shpi_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_group_ram (
      .clock   (clock),
      .wr_en   (grp_we),
      .wr_addr (blk_ff),
      .wr_data (grp_new),
      .rd_en   (cmd.load),
      .rd_addr (blk_in),
      .rd_data (grp_rd)
   );

   // Block resolution: insert at the start slot or scan onward
   always_comb begin
      for (int s = 0; s < 8; s++) begin
         sbyte[s] = st_rd[(7 - s) * 8 +: 8];
         gslot[s] = grp_rd[s * SLOT_W +: SLOT_W];
         empty[s] = (sbyte[s] == EMPTY_MARK);
         eq[s]    = (sbyte[s] == {1'b0, stamp_ff}) && (3'(s) >= from_ff);
      end
      hit = |eq;
      any = eq | empty;

      // first slot of interest, eight when there is none
      pos = 4'd8;
      for (int s = 7; s >= 0; s--) begin
         if (any[s]) begin
            pos = 4'(s);
         end
      end

      // new block contents for an insert
      for (int s = 0; s < 8; s++) begin
         st_new[(7 - s) * 8 +: 8]  = (3'(s) == from_ff) ? {1'b0, stamp_ff} : sbyte[s];
         grp_new[s * SLOT_W +: SLOT_W] = (3'(s) == from_ff) ? count_ff : gslot[s];
      end

      full    = (cmd_ff == CMD_PROBE) && (count_ff >= limit);
      ins     = (cmd_ff == CMD_PROBE) && !full && empty[from_ff];
      nxt_sum = {1'b0, blk_ff, 3'b000} + (SLOT_W + 1)'(pos) + (SLOT_W + 1)'(hit);

      if (full) begin
         match_in = 1'b0;
         gid_in   = '0;
         next_in  = '0;
      end else if (ins) begin
         match_in = 1'b0;
         gid_in   = count_ff;
         next_in  = {blk_ff, from_ff};
      end else begin
         match_in = hit;
         // a slot never filled since the last clear reports group id zero
         gid_in   = empty[pos[2:0]] ? '0 : gslot[pos[2:0]];
         next_in  = nxt_sum[SLOT_W-1:0] & slot_mask;
      end
   end

   // Write port: sweep writes empty words, insert writes the updated block
   always_comb begin
      st_we    = cmd.clr_write || (cmd.commit && ins);
      st_waddr = cmd.clr_write ? clr_ff : blk_ff;
      st_wr    = cmd.clr_write ? EMPTY_WORD : st_new;
      grp_we   = cmd.commit && ins;
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         match_ff <= match_in;
         ins_ff   <= ins;
         full_ff  <= full;
         gid_ff   <= gid_in;
         next_ff  <= next_in;
      end
   end

   assign stat.clr_last  = (clr_ff == bmask);
   assign stat.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = match_ff;
   assign rsp_inserted   = ins_ff;
   assign rsp_table_full = full_ff;
   assign rsp_gid        = gid_ff;
   assign rsp_next_slot  = next_ff;

`ifndef SYNTHESIS
   // a response reports at most one of match, insert and full
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({match_ff, ins_ff, full_ff}))
      else $error("conflicting response flags");

   // the fill count never passes the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= limit)
      else $error("inserted count above limit");
`endif

endmodule

### rtl/core/stamp_hash_table_probe_insert_core.sv
// Channel | Ports                                              | Beat
// req     | req_valid/req_ready, req_command, req_hash,        | one probe or lookup
//         | req_resume_slot                                    |
// rsp     | rsp_valid/rsp_ready, rsp_hit, rsp_inserted,        | one result
//         | rsp_table_full, rsp_gid, rsp_next_slot             |
// csr     | csr_valid/csr_ready, csr_log_blocks                | log_blocks write
//
// The block's stamp word and group row are read in the accept cycle, then
// resolved and written back once the response register is free.
// Reset and each log_blocks write start a sweep that empties the blocks in
// use (a single block after reset), one per cycle unless another log_blocks
// write restarts it; no requests are taken meanwhile. A full response register
// holds an item at resolution until taken; requests and log_blocks writes wait.
module stamp_hash_table_probe_insert_core
   import shpi_pkg::*;
#(
   parameter int unsigned LOG_BLOCKS_MAX = 10,
   parameter int unsigned HASH_BITS      = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_command,
   input  logic [HASH_PORT_W-1:0]    req_hash,
   input  logic [LOG_BLOCKS_MAX+2:0] req_resume_slot,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output logic                      rsp_inserted,
   output logic                      rsp_table_full,
   output logic [LOG_BLOCKS_MAX+2:0] rsp_gid,
   output logic [LOG_BLOCKS_MAX+2:0] rsp_next_slot,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [LB_PORT_W-1:0]      csr_log_blocks
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   shpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   shpi_dp #(
      .LOG_BLOCKS_MAX (LOG_BLOCKS_MAX),
      .HASH_BITS      (HASH_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .csr_log_blocks  (csr_log_blocks),
      .req_command     (req_command),
      .req_hash        (req_hash),
      .req_resume_slot (req_resume_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_inserted    (rsp_inserted),
      .rsp_table_full  (rsp_table_full),
      .rsp_gid         (rsp_gid),
      .rsp_next_slot   (rsp_next_slot)
   );

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb
   import shpi_pkg::*;
();

   localparam int unsigned SLOT_W          = 13;
   localparam int unsigned TABLE_BLOCKS    = 1024;
   localparam int unsigned TABLE_SLOTS     = 8192;
   localparam int unsigned LOG_BLOCKS_TOP  = 10;
   localparam int unsigned NUM_PHASES      = 14;
   localparam int unsigned PHASE_ITEMS     = 138;
   localparam int unsigned PRESSURE_PHASE  = 3;
   localparam int unsigned RSP_HOLD_CYCLES = 300;
   localparam int unsigned POOL_SIZE       = 24;
   localparam int unsigned MAX_CHAIN       = 12;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;
   localparam int unsigned REPORT_LIMIT    = 10;

   typedef struct packed {
      logic              hit;
      logic              inserted;
      logic              table_full;
      logic [SLOT_W-1:0] gid;
      logic [SLOT_W-1:0] next_slot;
   } probe_result_type;

   typedef struct {
      bit                is_cfg;
      logic [3:0]        cfg_value;
      logic              command;
      logic [31:0]       hash;
      logic [SLOT_W-1:0] resume_slot;
      bit                typed;
      probe_result_type  want;
   } plan_row_type;

   // Outcomes that can be read straight off the rules
   localparam probe_result_type OUT_CLEAR = '0;
   localparam probe_result_type OUT_FULL  = '{hit: 1'b0, inserted: 1'b0,
                                             table_full: 1'b1, gid: '0,
                                             next_slot: '0};

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_command;
   logic [31:0]       req_hash;
   logic [SLOT_W-1:0] req_resume_slot;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_hit;
   logic              rsp_inserted;
   logic              rsp_table_full;
   logic [SLOT_W-1:0] rsp_gid;
   logic [SLOT_W-1:0] rsp_next_slot;
   logic              csr_valid;
   logic              csr_ready;
   logic [3:0]        csr_log_blocks;

   // Shadow copy of the table
   logic [63:0]       shadow_stamps [TABLE_BLOCKS];
   logic [SLOT_W-1:0] shadow_groups [TABLE_SLOTS];
   int unsigned       shadow_count;
   int unsigned       shadow_log_blocks;

   probe_result_type  awaited_outcomes [$];
   plan_row_type      plan_rows [$];
   logic [31:0]       hash_pool [POOL_SIZE];
   logic [3:0]        phase_lb [NUM_PHASES] = '{4'd2, 4'd0, 4'd3, 4'd10, 4'd1, 4'd5, 4'd9,
                                               4'd15, 4'd4, 4'd7, 4'd6, 4'd8, 4'd0, 4'd12};

   int unsigned       fault_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       items_sent = 0;
   int unsigned       hold_requests = 0;
   bit                pacing_off = 1'b0;

   stamp_hash_table_probe_insert_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_hash        (req_hash),
      .req_resume_slot (req_resume_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_inserted    (rsp_inserted),
      .rsp_table_full  (rsp_table_full),
      .rsp_gid         (rsp_gid),
      .rsp_next_slot   (rsp_next_slot),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_log_blocks  (csr_log_blocks)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Table cleared: every slot empty, no groups handed out
   function automatic void clear_shadow();
      foreach (shadow_stamps[i]) shadow_stamps[i] = EMPTY_WORD;
      foreach (shadow_groups[i]) shadow_groups[i] = '0;
      shadow_count = 0;
   endfunction

   // Works out one beat's outcome and applies any insert to the shadow table
   function automatic probe_result_type resolve_probe(input logic command,
                                                      input logic [31:0] hash,
                                                      input logic [SLOT_W-1:0] resume_slot);
      probe_result_type r;
      int unsigned      slot_mask;
      int unsigned      blk;
      int unsigned      first_pos;
      int unsigned      pos;
      int unsigned      fill_limit;
      logic [6:0]       stamp;
      logic [7:0]       code;
      logic [63:0]      word;
      logic             hit;
      r         = '0;
      slot_mask = (8 << shadow_log_blocks) - 1;
      stamp     = 7'(hash >> (32 - STAMP_BITS - shadow_log_blocks));
      if (command == CMD_LOOKUP) begin
         blk       = (hash >> (32 - shadow_log_blocks)) & (slot_mask >> 3);
         first_pos = 0;
      end else begin
         blk       = (resume_slot & slot_mask) >> 3;
         first_pos = resume_slot & 7;
      end
      word = shadow_stamps[blk];

      if (command == CMD_PROBE) begin
         fill_limit = (shadow_log_blocks <= SMALL_LOG) ? (8 << shadow_log_blocks) / 2
                                                      : 3 * (8 << shadow_log_blocks) / 4;
         if (shadow_count >= fill_limit) begin
            r.table_full = 1'b1;
            return r;
         end
         // empty start slot: claim it with the next group id
         if (word[8*(7-first_pos) +: 8] == EMPTY_MARK) begin
            word[8*(7-first_pos) +: 8] = {1'b0, stamp};
            shadow_stamps[blk] = word;
            r.gid = SLOT_W'(shadow_count & slot_mask);
            shadow_groups[blk*8 + first_pos] = r.gid;
            shadow_count++;
            r.inserted  = 1'b1;
            r.next_slot = SLOT_W'(blk*8 + first_pos);
            return r;
         end
      end

      // first empty slot anywhere, or equal stamp from the start slot on;
      // the hit flag counts a later match even when an empty slot comes first
      pos = 8;
      hit = 1'b0;
      for (int s = 7; s >= 0; s--) begin
         code = word[8*(7-s) +: 8];
         if (code[7] || (s >= first_pos && code[6:0] == stamp))
            pos = s;
         if (!code[7] && s >= first_pos && code[6:0] == stamp)
            hit = 1'b1;
      end
      r.hit       = hit;
      r.gid       = SLOT_W'(shadow_groups[blk*8 + (pos & 7)] & slot_mask);
      r.next_slot = SLOT_W'((blk*8 + pos + hit) & slot_mask);
      return r;
   endfunction

   function automatic int unsigned idle_span();
      int unsigned roll;
      if (pacing_off)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   function automatic void plan_req(input logic command, input logic [31:0] hash,
                                    input logic [SLOT_W-1:0] resume_slot,
                                    input bit typed = 1'b0,
                                    input probe_result_type want = '0);
      plan_row_type row;
      row.is_cfg      = 1'b0;
      row.cfg_value   = '0;
      row.command     = command;
      row.hash        = hash;
      row.resume_slot = resume_slot;
      row.typed       = typed;
      row.want        = want;
      plan_rows.push_back(row);
   endfunction

   function automatic void plan_cfg(input logic [3:0] value);
      plan_row_type row;
      row           = '{default: '0};
      row.is_cfg    = 1'b1;
      row.cfg_value = value;
      plan_rows.push_back(row);
   endfunction

   task automatic log_fault(input string what, input probe_result_type want,
                            input probe_result_type seen);
      fault_count++;
      if (fault_count <= REPORT_LIMIT)
         $display("cycle %0d %s: exp h%0d i%0d f%0d g%0d n%0d, got h%0d i%0d f%0d g%0d n%0d",
                  cycle_count, what, want.hit, want.inserted, want.table_full,
                  want.gid, want.next_slot, seen.hit, seen.inserted,
                  seen.table_full, seen.gid, seen.next_slot);
   endtask

   // One request beat; valid stays up on return, the caller lowers it
   task automatic issue_probe(input logic command, input logic [31:0] hash,
                              input logic [SLOT_W-1:0] resume_slot,
                              output probe_result_type outcome,
                              input bit typed = 1'b0,
                              input probe_result_type want = '0);
      req_valid       <= 1'b1;
      req_command     <= command;
      req_hash        <= hash;
      req_resume_slot <= resume_slot;
      do @(posedge clock); while (!req_ready);
      outcome = resolve_probe(command, hash, resume_slot);
      awaited_outcomes.push_back(typed ? want : outcome);
      items_sent++;
   endtask

   task automatic pause_req(input int unsigned span);
      if (span != 0) begin
         req_valid <= 1'b0;
         repeat (span) @(posedge clock);
      end
   endtask

   // Sender goes quiet until every outstanding result is back
   task automatic settle_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_outcomes.size() != 0);
   endtask

   task automatic write_log_blocks(input logic [3:0] value);
      settle_results();
      csr_valid      <= 1'b1;
      csr_log_blocks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // oversized values saturate; any write empties the table
      shadow_log_blocks = (value > LOG_BLOCKS_TOP) ? LOG_BLOCKS_TOP : value;
      clear_shadow();
   endtask

   // Result checker
   always @(posedge clock) begin : rsp_check
      probe_result_type seen;
      probe_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{hit: rsp_hit, inserted: rsp_inserted,
                  table_full: rsp_table_full, gid: rsp_gid,
                  next_slot: rsp_next_slot};
         if (awaited_outcomes.size() == 0) begin
            log_fault("beat with nothing outstanding", '0, seen);
         end else begin
            want = awaited_outcomes.pop_front();
            if (seen.hit !== want.hit || seen.inserted !== want.inserted ||
                seen.table_full !== want.table_full || seen.gid !== want.gid ||
                seen.next_slot !== want.next_slot)
               log_fault("field mismatch", want, seen);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver pacing, with the occasional long hold-off
   initial begin : rsp_pacing
      int unsigned hold_served;
      int unsigned stall;
      hold_served = 0;
      rsp_ready   = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = idle_span();
            if (stall == 0) begin
               rsp_ready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      probe_result_type outcome;
      logic [31:0]      key;
      logic [31:0]      keep;
      logic [31:0]      fresh;
      int unsigned      phase_start;
      int unsigned      steps;
      int unsigned      pick;
      int unsigned      nbits;
      bit               mid_done;
      bit               chain_done;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = CMD_LOOKUP;
      req_hash        = '0;
      req_resume_slot = '0;
      csr_valid       = 1'b0;
      csr_log_blocks  = '0;
      shadow_log_blocks = 0;
      clear_shadow();

      // Directed rows, one block of eight after reset
      plan_req(CMD_LOOKUP, 32'h0000_0000, '0, 1'b1, OUT_CLEAR);
      plan_req(CMD_PROBE, 32'hFFFF_FFFF, '0, 1'b1,
               '{hit: 1'b0, inserted: 1'b1, table_full: 1'b0,
                 gid: '0, next_slot: '0});
      plan_req(CMD_PROBE, 32'hFFFF_FFFF, '0);           // stamp hit at the start slot
      plan_req(CMD_PROBE, 32'h0000_0000, 13'h1FFF);     // start slot beyond the table
      plan_req(CMD_PROBE, 32'h0200_0000, 13'd1);
      plan_req(CMD_PROBE, 32'h0000_0000, 13'd7);        // empty slot ahead of a match
      plan_req(CMD_LOOKUP, 32'h0000_0000, 13'h1FFF);
      plan_req(CMD_PROBE, 32'h0000_0000, 13'd2);        // fills to the limit
      plan_req(CMD_PROBE, 32'h1234_5678, 13'd3, 1'b1, OUT_FULL);
      // oversized setting saturates to the largest table
      plan_cfg(4'd15);
      plan_req(CMD_LOOKUP, 32'h0000_0000, '0, 1'b1, OUT_CLEAR);
      plan_req(CMD_PROBE, 32'hFFFF_FFFF, 13'h1FFF, 1'b1,
               '{hit: 1'b0, inserted: 1'b1, table_full: 1'b0,
                 gid: '0, next_slot: 13'h1FFF});
      plan_req(CMD_PROBE, 32'hFFFF_FFFF, 13'h1FFF);     // last slot, wraps
      plan_req(CMD_LOOKUP, 32'hFFFF_FFFF, '0);
      // two blocks: fill the upper one, then miss through it
      plan_cfg(4'd1);
      for (int k = 0; k < 8; k++)
         plan_req(CMD_PROBE, 32'h8000_0000 | ((32'h10 + k) << 24) | k, SLOT_W'(8 + k));
      plan_req(CMD_LOOKUP, 32'hFF00_0000, '0);          // no slot of interest, wraps
      plan_req(CMD_PROBE, 32'h0000_0000, '0, 1'b1, OUT_FULL);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan_rows[i]) begin
         if (plan_rows[i].is_cfg) begin
            write_log_blocks(plan_rows[i].cfg_value);
         end else begin
            issue_probe(plan_rows[i].command, plan_rows[i].hash, plan_rows[i].resume_slot,
                        outcome, plan_rows[i].typed, plan_rows[i].want);
            pause_req(idle_span());
         end
      end

      // Random phases, one table size each
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_log_blocks(phase_lb[p]);
         pacing_off = ($urandom_range(0, 3) == 0) || (p == PRESSURE_PHASE);

         // key pool with shared home blocks and shared stamps
         for (int i = 0; i < POOL_SIZE; i++) begin
            pick  = $urandom_range(0, 2);
            fresh = $urandom;
            if (i == 0 || pick == 0) begin
               hash_pool[i] = fresh;
            end else begin
               nbits = (pick == 1) ? shadow_log_blocks : shadow_log_blocks + STAMP_BITS;
               keep  = ~(32'hFFFF_FFFF >> nbits);
               hash_pool[i] = (hash_pool[$urandom_range(0, i - 1)] & keep) | (fresh & ~keep);
            end
         end

         phase_start = items_sent;
         mid_done    = 1'b0;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (!mid_done && items_sent - phase_start >= PHASE_ITEMS / 2) begin
               mid_done = 1'b1;
               settle_results();
               if (p == PRESSURE_PHASE)
                  hold_requests++;
            end

            if ($urandom_range(0, 99) < 20) begin
               // stray beats: random fields, or a key probed from anywhere
               if ($urandom_range(0, 1))
                  issue_probe(1'($urandom), $urandom, SLOT_W'($urandom), outcome);
               else
                  issue_probe(CMD_PROBE, hash_pool[$urandom_range(0, POOL_SIZE - 1)],
                              SLOT_W'($urandom_range(0, TABLE_SLOTS - 1)), outcome);
               pause_req(idle_span());
            end else begin
               // lookup, then follow the probe chain as a caller would
               key = hash_pool[$urandom_range(0, POOL_SIZE - 1)];
               issue_probe(CMD_LOOKUP, key, SLOT_W'($urandom), outcome);
               pause_req(idle_span());
               steps      = 0;
               chain_done = 1'b0;
               while (!chain_done) begin
                  if (outcome.table_full || outcome.inserted || steps >= MAX_CHAIN)
                     chain_done = 1'b1;
                  else if (outcome.hit && $urandom_range(0, 1))
                     chain_done = 1'b1;     // caller's key compare says equal
                  else begin
                     issue_probe(CMD_PROBE, key, outcome.next_slot, outcome);
                     pause_req(idle_span());
                     steps++;
                  end
               end
            end
         end
      end

      settle_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
rtl/core/shpi_pkg.sv
rtl/core/shpi_ram.sv
rtl/core/shpi_ctrl.sv
rtl/core/shpi_dp.sv
rtl/core/stamp_hash_table_probe_insert_core.sv
test/tb.sv
